### rtl/tmrt_pkg.sv
// shared types and constants for the texture memory region tracker
// depends on nothing; imported by tmrt_table, tmrt_ctrl and the top level

package tmrt_pkg;

    localparam int START_W  = 12;
    localparam int STOP_W   = 16;
    localparam int ADDR_W   = 32;
    localparam int LINE_W   = 13;
    localparam int FMT_W    = 4;
    localparam int SIZE_W   = 3;

    // request kinds carried on tuser
    localparam logic REQ_MARK   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // source address reported when a lookup finds nothing
    localparam logic [ADDR_W-1:0] MISS_ADDR = '1;

    typedef struct packed {
        logic                     kind;
        logic [START_W-1:0]       start;
        logic [STOP_W-1:0]        stop;
        logic [ADDR_W-1:0]        src_addr;
        logic [LINE_W-1:0]        src_line;
        logic signed [FMT_W-1:0]  src_fmt;
        logic signed [SIZE_W-1:0] src_size;
    } req_t;

    // one stored region, as held in the table memory
    typedef struct packed {
        logic [START_W-1:0]       area_begin;
        logic [STOP_W-1:0]        area_end;
        logic [ADDR_W-1:0]        origin;
        logic [LINE_W-1:0]        pitch;
        logic signed [FMT_W-1:0]  fmt;
        logic signed [SIZE_W-1:0] texel_size;
    } entry_t;

    typedef struct packed {
        logic                     hit;
        logic [ADDR_W-1:0]        origin_address;
        logic [LINE_W-1:0]        origin_line;
        logic [STOP_W-1:0]        area_end;
        logic signed [FMT_W-1:0]  origin_format;
        logic signed [SIZE_W-1:0] origin_size;
        logic                     table_flushed;
    } res_t;

endpackage

### rtl/tmrt_table.sv
// region table storage: one write port, one read port, registered read data
// depends on tmrt_pkg for the entry layout

module tmrt_table
    import tmrt_pkg::*;
#(
    parameter int AREA_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(AREA_SLOTS)-1:0] waddr,
    input  entry_t                        wdata,
    input  logic [$clog2(AREA_SLOTS)-1:0] raddr,
    output entry_t                        rdata
);

    entry_t mem [AREA_SLOTS];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tmrt_ctrl.sv
// request sequencer: scans the region table, compacts it in place on mark,
// appends the new region and forms the result; depends on tmrt_pkg

module tmrt_ctrl
    import tmrt_pkg::*;
#(
    parameter int AREA_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  req_t                          req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output res_t                          res,
    output logic                          mem_we,
    output logic [$clog2(AREA_SLOTS)-1:0] mem_waddr,
    output entry_t                        mem_wdata,
    output logic [$clog2(AREA_SLOTS)-1:0] mem_raddr,
    input  entry_t                        mem_rdata
);

    localparam int IDX_W = $clog2(AREA_SLOTS);
    localparam int CNT_W = $clog2(AREA_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(AREA_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    res_t             res_reg, res_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             chk_valid_reg, chk_valid_next;

    logic rd_req;
    logic overlap;
    logic flush;

    assign rd_req  = issue_reg < count_reg;
    assign overlap = ({{(STOP_W-START_W){1'b0}}, mem_rdata.area_begin} < req_reg.stop)
                  && (mem_rdata.area_end > {{(STOP_W-START_W){1'b0}}, req_reg.start});
    assign flush   = wr_ptr_reg == SLOTS_CNT;

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        wr_ptr_next    = wr_ptr_reg;
        chk_valid_next = chk_valid_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg[IDX_W-1:0];
        mem_wdata      = mem_rdata;
        mem_raddr      = issue_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next       = req;
                    issue_next     = '0;
                    wr_ptr_next    = '0;
                    chk_valid_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                chk_valid_next = rd_req;
                issue_next     = issue_reg + CNT_W'(rd_req);
                if (chk_valid_reg) begin
                    if (req_reg.kind == REQ_LOOKUP) begin
                        if (mem_rdata.area_begin == req_reg.start) begin
                            res_next.hit            = 1'b1;
                            res_next.origin_address = mem_rdata.origin;
                            res_next.origin_line    = mem_rdata.pitch;
                            res_next.area_end       = mem_rdata.area_end;
                            res_next.origin_format  = mem_rdata.fmt;
                            res_next.origin_size    = mem_rdata.texel_size;
                            res_next.table_flushed  = 1'b0;
                            chk_valid_next          = 1'b0;
                            state_next              = ST_RESULT;
                        end
                    end else if (!overlap) begin
                        // survivors slide down; wr_ptr never passes the read side
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end else if (!rd_req) begin
                    // scan drained
                    res_next                = '0;
                    state_next              = ST_RESULT;
                    if (req_reg.kind == REQ_LOOKUP) begin
                        res_next.origin_address = MISS_ADDR;
                    end else begin
                        res_next.table_flushed = flush;
                        mem_we                 = 1'b1;
                        mem_waddr              = flush ? '0 : wr_ptr_reg[IDX_W-1:0];
                        mem_wdata.area_begin   = req_reg.start;
                        mem_wdata.area_end     = req_reg.stop;
                        mem_wdata.origin       = req_reg.src_addr;
                        mem_wdata.pitch        = req_reg.src_line;
                        mem_wdata.fmt          = req_reg.src_fmt;
                        mem_wdata.texel_size   = req_reg.src_size;
                        count_next             = flush ? CNT_W'(1) : wr_ptr_reg + CNT_W'(1);
                    end
                end
            end
            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        issue_reg  <= issue_next;
        wr_ptr_reg <= wr_ptr_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SLOTS_CNT)
        else $error("region count beyond table size");

    a_compact_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && chk_valid_reg && mem_we) |-> wr_ptr_reg < issue_reg)
        else $error("compaction write overtook the read side");

    a_mark_appends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && state_next == ST_RESULT && req_reg.kind == REQ_MARK)
        |=> count_reg != '0)
        else $error("mark left the table empty");

    a_hit_no_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.hit && res.table_flushed))
        else $error("result flags both hit and flush");

endmodule

### rtl/texture_memory_region_tracker_unit.sv
// Texture memory region tracker. A request scans the n regions stored (at
// most AREA_SLOTS): the sequencer reads the single-port-read region table
// one entry per cycle, and a mark also writes each surviving entry back,
// compacted toward slot 0, in the same pass.
// A lookup stops at the first matching entry. The result sits in an output
// register, so the next request is taken while a result still waits.
// Depends on tmrt_pkg, tmrt_table and tmrt_ctrl.

module texture_memory_region_tracker_unit
    import tmrt_pkg::*;
#(
    parameter int AREA_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tmem_start, tmem_stop, source_address, source_line, source_format, source_size
    input  logic [79:0] s_tdata,
    // req_type
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // origin_address, origin_line, area_end, origin_format, origin_size,
    // table_flushed, 3 bits zero
    output logic [71:0] m_tdata,
    // hit
    output logic        m_tuser
);

    localparam int IDX_W = $clog2(AREA_SLOTS);

    req_t               req;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_wdata;
    entry_t             mem_rdata;

    logic out_valid_reg;
    res_t out_reg;

    assign req.kind     = s_tuser;
    assign req.start    = s_tdata[11:0];
    assign req.stop     = s_tdata[27:12];
    assign req.src_addr = s_tdata[59:28];
    assign req.src_line = s_tdata[72:60];
    assign req.src_fmt  = s_tdata[76:73];
    assign req.src_size = s_tdata[79:77];

    tmrt_ctrl #(
        .AREA_SLOTS(AREA_SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tmrt_table #(
        .AREA_SLOTS(AREA_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output stage: refill as soon as the held transfer goes
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {3'b000, out_reg.table_flushed, out_reg.origin_size,
                       out_reg.origin_format, out_reg.area_end,
                       out_reg.origin_line, out_reg.origin_address};

endmodule
